// ===== rtl/hsu_pkg.sv =====
`default_nettype none
package hsu_pkg;

   localparam int SITES  = 64;
   localparam int SITE_W = $clog2(SITES);

   localparam int COMP_W = 16;
   localparam int SPIN_W = 3 * COMP_W;
   localparam int J_W    = 8;
   localparam int J2_W   = J_W + 1;
   localparam int D_W    = COMP_W + 1;
   localparam int PROD_W = D_W + COMP_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int ACC_W  = DOT_W + SITE_W;
   localparam int DE_W   = ACC_W + J2_W;
   localparam int E_W    = 48;

   localparam logic signed [J_W-1:0] COUPLING_RESET = -8'sd16;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PROPOSE = 1'b1;

   typedef struct packed {
      logic pend;
      logic valid;
   } hsu_dot_status_type;

endpackage
`default_nettype wire

// ===== rtl/hsu_ram.sv =====
`default_nettype none
module hsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/hsu_dot.sv =====
`default_nettype none
module hsu_dot
   import hsu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic signed [D_W-1:0]    d_x,
   input  wire logic signed [D_W-1:0]    d_y,
   input  wire logic signed [D_W-1:0]    d_z,
   input  wire logic [SPIN_W-1:0]        spin,
   output hsu_dot_status_type            status,
   output logic signed [DOT_W-1:0]       dot
);

   logic signed [COMP_W-1:0] s_x, s_y, s_z;
   logic signed [PROD_W-1:0] p_x_ff, p_y_ff, p_z_ff;
   logic signed [PROD_W-1:0] p_x_in, p_y_in, p_z_in;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic                     p_v_ff, dot_v_ff;

   assign s_x = $signed(spin[COMP_W-1:0]);
   assign s_y = $signed(spin[2*COMP_W-1:COMP_W]);
   assign s_z = $signed(spin[3*COMP_W-1:2*COMP_W]);

   assign p_x_in = d_x * s_x;
   assign p_y_in = d_y * s_y;
   assign p_z_in = d_z * s_z;

   assign dot_in = DOT_W'(p_x_ff) + DOT_W'(p_y_ff) + DOT_W'(p_z_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff   <= 1'b0;
         dot_v_ff <= 1'b0;
      end else begin
         p_v_ff   <= in_valid;
         dot_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_x_ff <= p_x_in;
      p_y_ff <= p_y_in;
      p_z_ff <= p_z_in;
      dot_ff <= dot_in;
   end

   assign status.pend  = p_v_ff;
   assign status.valid = dot_v_ff;
   assign dot          = dot_ff;

endmodule
`default_nettype wire

// ===== rtl/heisenberg_spin_update_core.sv =====
`default_nettype none
// Load: busy stays low, one beat per cycle; the answer beat follows in the cycle after start.
// Proposal: busy through the S_OLD, S_SWEEP, S_DRAIN, S_SCALE and S_DONE states;
// the sweep reads one stored spin per cycle from the single-read-port spin memory.
// The answer beat shows as busy falls, when the next beat can already be taken.
// Synchronous reset returns to idle and sets coupling to -1.0; the spin
// memory is not cleared and holds garbage until each site is loaded.
module heisenberg_spin_update_core
   import hsu_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_func,
   input  wire logic [SITE_W-1:0]        req_site,
   input  wire logic signed [COMP_W-1:0] req_spin_x,
   input  wire logic signed [COMP_W-1:0] req_spin_y,
   input  wire logic signed [COMP_W-1:0] req_spin_z,
   output logic                          rsp_strobe,
   output logic [SITE_W-1:0]             rsp_site_out,
   output logic                          rsp_accepted,
   output logic signed [E_W-1:0]         rsp_energy_change,
   input  wire logic                     csr_wr_en,
   input  wire logic signed [J_W-1:0]    csr_wr_data
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_OLD   = 6'b000010,
      S_SWEEP = 6'b000100,
      S_DRAIN = 6'b001000,
      S_SCALE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   localparam logic [SITE_W-1:0] LAST = SITE_W'(SITES - 1);
   localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
   localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

   state_type state_ff, state_in;

   logic signed [J_W-1:0]    coupling_ff;
   logic [SITE_W-1:0]        site_ff, idx_ff, idx_in;
   logic signed [COMP_W-1:0] nv_x_ff, nv_y_ff, nv_z_ff;
   logic signed [D_W-1:0]    d_x_ff, d_y_ff, d_z_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DE_W-1:0]   de_ff, de_in;
   logic signed [J2_W-1:0]   j2;
   logic                     rd_v_ff, rd_v_in;

   logic                     accept, in_range, de_neg;
   logic [SITE_W-1:0]        rd_addr, wr_addr;
   logic [SPIN_W-1:0]        rd_data, wr_data;
   logic                     wr_en;
   logic signed [COMP_W-1:0] old_x, old_y, old_z;
   logic signed [E_W-1:0]    de_sat;
   logic [DE_W-E_W:0]        de_top;

   hsu_dot_status_type       dot_status;
   logic signed [DOT_W-1:0]  dot;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [SITE_W-1:0]        rsp_site_ff, rsp_site_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   logic signed [E_W-1:0]    rsp_de_ff, rsp_de_in;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign in_range = (32'(req_site) < SITES);
   assign j2       = {coupling_ff, 1'b0};
   assign de_neg   = de_ff[DE_W-1];

   assign old_x = $signed(rd_data[COMP_W-1:0]);
   assign old_y = $signed(rd_data[2*COMP_W-1:COMP_W]);
   assign old_z = $signed(rd_data[3*COMP_W-1:2*COMP_W]);

   assign rd_addr = (state_ff == S_IDLE) ? req_site : idx_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_site;
      wr_data = {req_spin_z, req_spin_y, req_spin_x};
      if (state_ff == S_DONE) begin
         wr_en   = de_neg;
         wr_addr = site_ff;
         wr_data = {nv_z_ff, nv_y_ff, nv_x_ff};
      end else if (accept && req_func == FUNC_LOAD && in_range) begin
         wr_en = 1'b1;
      end
   end

   hsu_ram #(
      .WIDTH(SPIN_W),
      .DEPTH(SITES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   hsu_dot u_dot (
      .clock (clock),
      .reset (reset),
      .in_valid(rd_v_ff),
      .d_x   (d_x_ff),
      .d_y   (d_y_ff),
      .d_z   (d_z_ff),
      .spin  (rd_data),
      .status(dot_status),
      .dot   (dot)
   );

   assign de_in  = j2 * acc_ff;
   assign de_top = de_ff[DE_W-1:E_W-1];

   always_comb begin
      if ((&de_top) || !(|de_top)) begin
         de_sat = de_ff[E_W-1:0];
      end else if (de_neg) begin
         de_sat = E_MIN;
      end else begin
         de_sat = E_MAX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rd_v_in       = 1'b0;
      acc_in        = acc_ff;
      rsp_strobe_in = 1'b0;
      rsp_site_in   = rsp_site_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_de_in     = rsp_de_ff;
      if (dot_status.valid) begin
         acc_in = acc_ff + ACC_W'(dot);
      end
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            acc_in = '0;
            if (accept) begin
               if (req_func == FUNC_PROPOSE && in_range) begin
                  state_in = S_OLD;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_site_in   = req_site;
                  rsp_acc_in    = 1'b0;
                  rsp_de_in     = '0;
               end
            end
         end
         S_OLD: begin
            rd_v_in  = (idx_ff != site_ff);
            idx_in   = idx_ff + 1'b1;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            rd_v_in = (idx_ff != site_ff);
            if (idx_ff == LAST) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!rd_v_ff && !dot_status.pend && !dot_status.valid) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_site_in   = site_ff;
            rsp_acc_in    = de_neg;
            rsp_de_in     = de_sat;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_v_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         coupling_ff   <= COUPLING_RESET;
      end else begin
         state_ff      <= state_in;
         rd_v_ff       <= rd_v_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            coupling_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      rsp_site_ff <= rsp_site_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_de_ff   <= rsp_de_in;
      if (accept) begin
         site_ff <= req_site;
         nv_x_ff <= req_spin_x;
         nv_y_ff <= req_spin_y;
         nv_z_ff <= req_spin_z;
      end
      if (state_ff == S_OLD) begin
         d_x_ff <= D_W'(nv_x_ff) - D_W'(old_x);
         d_y_ff <= D_W'(nv_y_ff) - D_W'(old_y);
         d_z_ff <= D_W'(nv_z_ff) - D_W'(old_z);
      end
      if (state_ff == S_SCALE) begin
         de_ff <= de_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_site_out      = rsp_site_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_energy_change = rsp_de_ff;

endmodule
`default_nettype wire

// ===== rtl/hsu_checker.sv =====
`default_nettype none
module hsu_checker
   import hsu_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     req_func,
   input wire logic [SITE_W-1:0]        req_site,
   input wire logic                     rsp_strobe,
   input wire logic [SITE_W-1:0]        rsp_site_out,
   input wire logic                     rsp_accepted,
   input wire logic signed [E_W-1:0]    rsp_energy_change
);

   // load beat answered next cycle with no change and no acceptance
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_LOAD |=>
         rsp_strobe && !busy && !rsp_accepted && rsp_energy_change == '0
         && rsp_site_out == $past(req_site))
      else $error("load beat not answered correctly");

   a_prop_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_PROPOSE && 32'(req_site) < SITES |=> busy)
      else $error("proposal did not raise busy");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("proposal finished without answer");

   a_acc_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_accepted |-> rsp_energy_change[E_W-1])
      else $error("accepted with non-negative energy change");

   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) && !$past(reset) |-> !rsp_strobe)
      else $error("answer beat during proposal");

endmodule

bind heisenberg_spin_update_core hsu_checker u_hsu_checker (.*);
`default_nettype wire
